### hdl/ntp_seconds_to_calendar_defines.svh
// Assertion macros shared by the calendar converter modules.
`ifndef NTP_SECONDS_TO_CALENDAR_DEFINES_SVH
`define NTP_SECONDS_TO_CALENDAR_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, off during reset
`define NTPCAL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, off during reset
`define NTPCAL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define NTPCAL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NTPCAL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/ntpcal_pkg.sv
package ntpcal_pkg;

  localparam logic [10:0] FirstYear    = 11'd1900;
  localparam logic [31:0] DaySecs      = 32'd86400;
  localparam logic [31:0] HourSecs     = 32'd3600;
  localparam logic [31:0] YearSecs     = 32'd365 * DaySecs;
  localparam logic [31:0] LeapYearSecs = 32'd366 * DaySecs;

  // Days of each month, January first, February in a common year
  localparam logic [4:0] MonthDays [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [3:0] LastMonth = 4'd11;

  typedef enum logic [1:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR
  } ntpcal_phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_HOUR,
    S_MUL,
    S_SPLIT,
    S_EMIT
  } ntpcal_state_t;

  typedef struct packed {
    logic          load;
    logic          step;
    logic          mul;
    logic          split;
    logic          emit;
    ntpcal_phase_t phase;
  } ntpcal_cmd_t;

  typedef struct packed {
    logic ge;
    logic out_free;
  } ntpcal_stat_t;

  // Length of a month in seconds, February stretched in leap years
  function automatic logic [31:0] month_secs(input logic [3:0] idx, input logic leap);
    logic [4:0] days;
    days = (idx > LastMonth) ? 5'd31 : MonthDays[idx];
    if (idx == 4'd1 && leap) begin
      days = 5'd29;
    end
    return 32'(days) * DaySecs;
  endfunction

endpackage

### hdl/ntpcal_ifs.sv
interface ntpcal_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] ntp_seconds;

  modport source (output valid, output ntp_seconds, input ready);
  modport sink (input valid, input ntp_seconds, output ready);
endinterface

interface ntpcal_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  sec_of_minute;
  logic [5:0]  min_of_hour;
  logic [4:0]  hour_of_day;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [10:0] year_number;

  modport source (output valid, output sec_of_minute, output min_of_hour,
                  output hour_of_day, output day_of_month, output month_number,
                  output year_number, input ready);
  modport sink (input valid, input sec_of_minute, input min_of_hour,
                input hour_of_day, input day_of_month, input month_number,
                input year_number, output ready);
endinterface

### hdl/ntpcal_ctrl.sv
`include "ntp_seconds_to_calendar_defines.svh"

module ntpcal_ctrl
  import ntpcal_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ntpcal_stat_t stat,
  output ntpcal_cmd_t  cmd
);

  ntpcal_state_t state;
  ntpcal_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: each peel phase loops while the remainder still covers a unit
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_YEAR;
      end
      S_YEAR: begin
        if (!stat.ge) state_next = S_MONTH;
      end
      S_MONTH: begin
        if (!stat.ge) state_next = S_DAY;
      end
      S_DAY: begin
        if (!stat.ge) state_next = S_HOUR;
      end
      S_HOUR: begin
        if (!stat.ge) state_next = S_MUL;
      end
      S_MUL:   state_next = S_SPLIT;
      S_SPLIT: state_next = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd       = '0;
    cmd.phase = PH_YEAR;
    in_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_YEAR: begin
        cmd.phase = PH_YEAR;
        cmd.step  = stat.ge;
      end
      S_MONTH: begin
        cmd.phase = PH_MONTH;
        cmd.step  = stat.ge;
      end
      S_DAY: begin
        cmd.phase = PH_DAY;
        cmd.step  = stat.ge;
      end
      S_HOUR: begin
        cmd.phase = PH_HOUR;
        cmd.step  = stat.ge;
      end
      S_MUL:   cmd.mul   = 1'b1;
      S_SPLIT: cmd.split = 1'b1;
      S_EMIT:  cmd.emit  = stat.out_free;
      default: cmd = '0;
    endcase
  end

  `NTPCAL_ASSERT_IMP(a_emit_slot_free, clk, rst, cmd.emit, stat.out_free)
  `NTPCAL_ASSERT_IMP(a_step_only_when_ge, clk, rst, cmd.step, stat.ge)

endmodule

### hdl/ntpcal_dp.sv
`include "ntp_seconds_to_calendar_defines.svh"

module ntpcal_dp
  import ntpcal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ntpcal_cmd_t       cmd,
  output ntpcal_stat_t      stat,
  input  logic [31:0]       ntp_seconds,
  input  logic signed [4:0] zone_hours,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [5:0]        sec_of_minute,
  output logic [5:0]        min_of_hour,
  output logic [4:0]        hour_of_day,
  output logic [4:0]        day_of_month,
  output logic [3:0]        month_number,
  output logic [10:0]       year_number
);

  logic [31:0] t;
  logic [10:0] year;
  logic [1:0]  y4;
  logic [6:0]  y100;
  logic [8:0]  y400;
  logic [3:0]  month_idx;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [22:0] prod;
  logic [5:0]  minute;

  logic signed [17:0] zone_secs;
  logic [31:0]        t_start;
  logic               leap;
  logic [31:0]        unit_len;
  logic [11:0]        sec_rest;

  // Apply zone offset, wrapping modulo 2^32
  assign zone_secs = 18'(zone_hours) * 18'sd3600;
  assign t_start   = ntp_seconds + 32'(zone_secs);

  // Gregorian leap rule from the running residues of the year
  assign leap = (y4 == 2'd0) && ((y100 != 7'd0) || (y400 == 9'd0));

  // Select the unit peeled off in the current phase
  always_comb begin
    case (cmd.phase)
      PH_YEAR:  unit_len = leap ? LeapYearSecs : YearSecs;
      PH_MONTH: unit_len = month_secs(month_idx, leap);
      PH_DAY:   unit_len = DaySecs;
      PH_HOUR:  unit_len = HourSecs;
      default:  unit_len = DaySecs;
    endcase
  end

  assign stat.ge       = (t >= unit_len);
  assign stat.out_free = !out_valid || out_ready;

  // Peel registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t         <= t_start;
      year      <= FirstYear;
      y4        <= 2'd0;
      y100      <= 7'd0;
      y400      <= 9'd300;
      month_idx <= 4'd0;
      day       <= 5'd1;
      hour      <= 5'd0;
    end else if (cmd.step) begin
      t <= t - unit_len;
      case (cmd.phase)
        PH_YEAR: begin
          year <= year + 11'd1;
          y4   <= y4 + 2'd1;
          y100 <= (y100 == 7'd99) ? 7'd0 : y100 + 7'd1;
          y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
        end
        PH_MONTH: month_idx <= month_idx + 4'd1;
        PH_DAY:   day <= day + 5'd1;
        PH_HOUR:  hour <= hour + 5'd1;
        default:  hour <= hour;
      endcase
    end
  end

  // Split the last hour: minute = rest * 2185 >> 17 is exact below 3600
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 23'(t[11:0]) * 23'd2185;
    end
    if (cmd.split) begin
      minute <= prod[22:17];
    end
  end

  assign sec_rest = t[11:0] - 12'(minute) * 12'd60;

  // Output slot: hold until the transfer, then drop valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sec_of_minute <= sec_rest[5:0];
      min_of_hour   <= minute;
      hour_of_day   <= hour;
      day_of_month  <= day;
      month_number  <= month_idx + 4'd1;
      year_number   <= year;
    end
  end

  `NTPCAL_ASSERT_IMP(a_month_in_range, clk, rst,
                     cmd.step && cmd.phase == PH_MONTH, month_idx != LastMonth)
  `NTPCAL_ASSERT_IMP(a_rest_below_hour, clk, rst, cmd.mul, t < HourSecs)
  `NTPCAL_ASSERT_NXT(a_emit_sets_valid, clk, rst, cmd.emit, out_valid)

endmodule

### hdl/ntp_seconds_to_calendar.sv
// Converts a 32-bit NTP seconds count (epoch 1900-01-01) plus a signed whole-hour
// zone offset into second, minute, hour, day, month and year. One item is
// converted at a time. The year loop removes one year per cycle (up to 136
// years), followed by up to 11 month, 30 day and 23 hour steps of the same
// subtractor; each of the four phases ends once the remainder is below its
// unit. The S_MUL, S_SPLIT and S_EMIT states then split the last hour and load
// the result register, S_EMIT waiting until the output slot is free.
// The zone register (reset +3 hours) must be written only while no conversion
// is in flight.
module ntp_seconds_to_calendar
  import ntpcal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [4:0]        cfg_wr_data,
  ntpcal_in_if.sink         ntp_in,
  ntpcal_out_if.source      cal_out
);

  logic signed [4:0] zone_hours;
  ntpcal_cmd_t       cmd;
  ntpcal_stat_t      stat;
  logic              in_ready;

  // Zone offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_hours <= 5'sd3;
    end else if (cfg_wr_en) begin
      zone_hours <= cfg_wr_data;
    end
  end

  assign ntp_in.ready = in_ready;

  ntpcal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ntp_in.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ntpcal_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .ntp_seconds   (ntp_in.ntp_seconds),
    .zone_hours    (zone_hours),
    .out_ready     (cal_out.ready),
    .out_valid     (cal_out.valid),
    .sec_of_minute (cal_out.sec_of_minute),
    .min_of_hour   (cal_out.min_of_hour),
    .hour_of_day   (cal_out.hour_of_day),
    .day_of_month  (cal_out.day_of_month),
    .month_number  (cal_out.month_number),
    .year_number   (cal_out.year_number)
  );

endmodule

### verif/ntp_seconds_to_calendar_tb.sv
module ntp_seconds_to_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned BASE_YEAR     = 1900;
  localparam int unsigned IDLE_PCT      = 22;
  localparam int unsigned HOLD_AFTER    = 400;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned DRAIN_CYCLES  = 250;
  localparam int unsigned ITEMS_PER_ZONE = 90;

  // Zone settings by name
  localparam logic [4:0] ZONE_RESET  = 5'd3;
  localparam logic [4:0] ZONE_UTC    = 5'd0;
  localparam logic [4:0] ZONE_WEST   = 5'b10100;  // -12
  localparam logic [4:0] ZONE_EAST   = 5'd14;
  localparam logic [4:0] ZONE_NEG_MAX = 5'b10000; // -16
  localparam logic [4:0] ZONE_POS_MAX = 5'd15;

  typedef struct packed {
    logic [5:0]  sec_of_minute;
    logic [5:0]  min_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [10:0] year_number;
  } civil_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;

  ntpcal_in_if  ntp_in ();
  ntpcal_out_if cal_out ();

  ntp_seconds_to_calendar uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ntp_in      (ntp_in),
    .cal_out     (cal_out)
  );

  logic [31:0] seconds_queue [$];
  civil_t      calendar_due [$];
  logic [4:0]  zone_now = ZONE_RESET;
  logic        calm = 1'b0;
  int unsigned sent_count = 0;
  int unsigned faults = 0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  always #5 clk = ~clk;

  initial begin
    ntp_in.valid        = 1'b0;
    ntp_in.ntp_seconds  = '0;
    cal_out.ready       = 1'b0;
  end

  function automatic logic leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Expected calendar fields for one count under the given zone
  function automatic civil_t civil_time(input logic [31:0] ntp_secs, input logic [4:0] zone);
    int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    logic [31:0] t;
    logic [31:0] span;
    int unsigned yr;
    int unsigned mon;
    civil_t r;
    t = ntp_secs + 32'(int'($signed(zone)) * int'(SECS_PER_HOUR));
    yr = BASE_YEAR;
    forever begin
      span = SECS_PER_DAY * (leap_year(yr) ? 366 : 365);
      if (t < span) break;
      t -= span;
      yr++;
    end
    mon = 0;
    while (mon < 11) begin
      span = SECS_PER_DAY * ((mon == 1 && leap_year(yr)) ? 29 : month_len[mon]);
      if (t < span) break;
      t -= span;
      mon++;
    end
    r.year_number   = 11'(yr);
    r.month_number  = 4'(mon + 1);
    r.day_of_month  = 5'(t / SECS_PER_DAY + 1);
    t = t % SECS_PER_DAY;
    r.hour_of_day   = 5'(t / SECS_PER_HOUR);
    t = t % SECS_PER_HOUR;
    r.min_of_hour   = 6'(t / 60);
    r.sec_of_minute = 6'(t % 60);
    return r;
  endfunction

  // Random count: plain, near a day boundary, at a year start, or near either end
  function automatic logic [31:0] pick_seconds();
    logic [31:0] s;
    int unsigned y;
    int unsigned target;
    case ($urandom_range(0, 5))
      0, 1, 2: s = $urandom;
      3: s = 32'($urandom_range(0, 49710) * SECS_PER_DAY) - 32'd2 + 32'($urandom_range(0, 4));
      4: begin
        target = $urandom_range(BASE_YEAR + 1, 2036);
        s = '0;
        for (y = BASE_YEAR; y < target; y++) begin
          s += SECS_PER_DAY * (leap_year(y) ? 366 : 365);
        end
        s = s - 32'd1 + 32'($urandom_range(0, 2));
      end
      default: begin
        s = 32'($urandom_range(0, 17 * SECS_PER_HOUR));
        if ($urandom_range(0, 1) == 1) s = ~s;
      end
    endcase
    return s;
  endfunction

  // Driver: offer pending counts, predict at each transfer
  always @(posedge clk) begin
    if (rst) begin
      ntp_in.valid <= 1'b0;
    end else begin
      if (ntp_in.valid && ntp_in.ready) begin
        calendar_due.push_back(civil_time(ntp_in.ntp_seconds, zone_now));
        sent_count++;
      end
      if (!ntp_in.valid || ntp_in.ready) begin
        if (seconds_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          ntp_in.valid       <= 1'b1;
          ntp_in.ntp_seconds <= seconds_queue.pop_front();
        end else begin
          ntp_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, stall at random and once for a long stretch
  always @(posedge clk) begin
    civil_t got;
    civil_t want;
    if (rst) begin
      cal_out.ready <= 1'b0;
    end else begin
      if (cal_out.valid && cal_out.ready) begin
        got.sec_of_minute = cal_out.sec_of_minute;
        got.min_of_hour   = cal_out.min_of_hour;
        got.hour_of_day   = cal_out.hour_of_day;
        got.day_of_month  = cal_out.day_of_month;
        got.month_number  = cal_out.month_number;
        got.year_number   = cal_out.year_number;
        if (calendar_due.size() == 0) begin
          if (faults < 10)
            $display("%0t: result with none pending: %0d-%0d-%0d %0d:%0d:%0d", $realtime,
                     got.year_number, got.month_number, got.day_of_month,
                     got.hour_of_day, got.min_of_hour, got.sec_of_minute);
          faults++;
        end else begin
          want = calendar_due.pop_front();
          if (got.sec_of_minute !== want.sec_of_minute || got.min_of_hour !== want.min_of_hour ||
              got.hour_of_day !== want.hour_of_day || got.day_of_month !== want.day_of_month ||
              got.month_number !== want.month_number || got.year_number !== want.year_number) begin
            if (faults < 10)
              $display("%0t: mismatch: expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                       $realtime, want.year_number, want.month_number, want.day_of_month,
                       want.hour_of_day, want.min_of_hour, want.sec_of_minute,
                       got.year_number, got.month_number, got.day_of_month,
                       got.hour_of_day, got.min_of_hour, got.sec_of_minute);
            faults++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        cal_out.ready <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AFTER) begin
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        cal_out.ready <= 1'b0;
      end else begin
        cal_out.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Sample at the falling edge so that every update of the rising edge has settled
  task automatic wait_idle();
    while (seconds_queue.size() > 0 || calendar_due.size() > 0 || ntp_in.valid)
      @(negedge clk);
  endtask

  // Write the zone register once the converter is empty
  task automatic set_zone(input logic [4:0] zone);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= zone;
    zone_now     = zone;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) seconds_queue.push_back(pick_seconds());
  endtask

  // Stimulus sequence
  initial begin
    int unsigned k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset zone: extremes and the upward wrap past the top of the count
    seconds_queue.push_back(32'd0);
    seconds_queue.push_back(32'hFFFF_FFFF);
    seconds_queue.push_back(32'hFFFF_FFFF - 3 * SECS_PER_HOUR + 1);
    seconds_queue.push_back(SECS_PER_DAY - 3 * SECS_PER_HOUR);

    // UTC: time-of-day, month, leap and century boundaries
    set_zone(ZONE_UTC);
    seconds_queue.push_back(32'd59);
    seconds_queue.push_back(32'd60);
    seconds_queue.push_back(32'd3599);
    seconds_queue.push_back(32'd86399);
    seconds_queue.push_back(32'd86400);
    seconds_queue.push_back(32'd5097599);     // last day of February in 1900
    seconds_queue.push_back(32'd5097600);     // 1900 is not a leap year
    seconds_queue.push_back(32'd31535999);    // end of 1900
    seconds_queue.push_back(32'd131241600);   // February 29, 1904
    seconds_queue.push_back(32'd3160771200);  // February 29, 2000
    seconds_queue.push_back(32'hFFFF_FFFF);
    push_random(ITEMS_PER_ZONE);

    // Negative zone wraps small counts down to 2036
    set_zone(ZONE_WEST);
    seconds_queue.push_back(32'd0);
    seconds_queue.push_back(32'd43199);
    seconds_queue.push_back(32'd43200);
    push_random(ITEMS_PER_ZONE);

    // Positive zone wraps the top of the count; no idling on either side
    set_zone(ZONE_EAST);
    calm = 1'b1;
    seconds_queue.push_back(32'hFFFF_FFFF);
    seconds_queue.push_back(32'hFFFF_FFFF - 14 * SECS_PER_HOUR);
    push_random(ITEMS_PER_ZONE);
    wait_idle();
    calm = 1'b0;

    // Offsets beyond the intended range
    set_zone(ZONE_NEG_MAX);
    seconds_queue.push_back(32'd0);
    push_random(ITEMS_PER_ZONE);
    set_zone(ZONE_POS_MAX);
    seconds_queue.push_back(32'hFFFF_FFFF);
    push_random(ITEMS_PER_ZONE);

    for (k = 0; k < 3; k++) begin
      set_zone(5'($urandom_range(0, 31)));
      push_random(ITEMS_PER_ZONE);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0 && calendar_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
